@@ hdl/sdmt_pkg.sv @@
// Shared types and constants of the direction mixture tracker.
`default_nettype none
package sdmt_pkg;

  localparam int unsigned WOne   = 65536;
  localparam int unsigned VarCap = 16777215;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DEG  = 3'd0,
    REG_KEEP = 3'd1,
    REG_ZONE = 3'd2,
    REG_RATE = 3'd3,
    REG_MINS = 3'd4,
    REG_MAXS = 3'd5,
    REG_WAIT = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  deg;
    logic [15:0] keep;
    logic [11:0] zone;
    logic [15:0] rate;
    logic [12:0] minsd;
    logic [12:0] maxsd;
    logic [7:0]  wait_n;
  } cfg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_BEAM  = 4'd2,
    OP_SLOW  = 4'd3,
    OP_CLAIM = 4'd4,
    OP_MEAN  = 4'd5,
    OP_VAR   = 4'd6,
    OP_WGT   = 4'd7,
    OP_NEWG  = 4'd8,
    OP_MISS  = 4'd9,
    OP_NORMB = 4'd10,
    OP_NORMF = 4'd11,
    OP_FIN   = 4'd12
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   start;   // first cycle of an operation
    logic   sel_fore; // operate on the speaker component
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // current operation finished
    logic present;
    logic claim;     // last claim test passed
    logic can_new;   // miss count reached the wait
    logic need_norm; // weight sum needs renormalising
  } dp_sts_t;

endpackage
`default_nettype wire

@@ hdl/sdmt_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned.
`default_nettype none
module sdmt_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 25
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      quo_o,
  output logic [DenW-1:0]      rem_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   trial;

  always_comb begin
    trial = {rem_q, quo_q[NumW-1]};
    quo_d = {quo_q[NumW-2:0], 1'b0};
    rem_d = trial[DenW-1:0];
    cnt_d = cnt_q;
    if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d    = DenW'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NumW);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != '0) || start_i;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

@@ hdl/sdmt_datapath.sv @@
// Datapath: beam filter, slow track, mixture state and shared divider.
`default_nettype none
module sdmt_datapath #(
  parameter int unsigned FracBits = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sdmt_pkg::cfg_t   cfg_i,
  input  wire logic             load_i,
  input  wire logic             has_data_i,
  input  wire logic [7:0]       peak_bin_i,
  input  wire logic             voice_i,
  input  wire sdmt_pkg::dp_cmd_t cmd_i,
  output sdmt_pkg::dp_sts_t     sts_o,
  output logic signed [15:0]    beam_o,
  output logic signed [15:0]    slow_o,
  output logic signed [15:0]    talk_o,
  output logic                  fore_o,
  output logic signed [15:0]    run_o
);
  import sdmt_pkg::*;

  localparam int unsigned VarShift = 16 - FracBits;

  // State
  logic signed [15:0] older_q, newer_q, beam_q, slow_q, bmean_q, fmean_q, talk_q, run_q;
  logic [23:0] bvar_q, fvar_q;
  logic [16:0] bw_q, fw_q;
  logic [7:0]  miss_q;
  logic        fflag_q, present_q, voice_q, claim_q;
  logic [7:0]  bin_q;

  // Working registers
  logic signed [16:0] dev_q;    // x - mean
  logic [31:0]        prod_q;   // registered product
  logic [23:0]        zsq_q;    // zone squared
  logic [16:0]        nbw_q;    // renormalised background weight
  logic               div_go_q;
  logic [1:0]         phase_q;

  // Selected component
  logic signed [15:0] m_sel;
  logic [23:0]        v_sel;
  logic [16:0]        w_sel;
  assign m_sel = cmd_i.sel_fore ? fmean_q : bmean_q;
  assign v_sel = cmd_i.sel_fore ? fvar_q  : bvar_q;
  assign w_sel = cmd_i.sel_fore ? fw_q    : bw_q;

  // Variance limits
  logic [25:0] lo_sq, hi_sq;
  logic [24:0] lo_var, hi_var;
  assign lo_sq  = 26'(cfg_i.minsd) * 26'(cfg_i.minsd);
  assign hi_sq  = 26'(cfg_i.maxsd) * 26'(cfg_i.maxsd);
  assign lo_var = 25'((lo_sq + (26'd1 << (VarShift - 1))) >> VarShift);
  assign hi_var = 25'((hi_sq + (26'd1 << (VarShift - 1))) >> VarShift);

  // Shared divider: magnitude numerator, sign applied afterwards
  logic [47:0] dnum_q;
  logic [24:0] dden_q;
  logic        dneg_q;
  logic        dbusy;
  logic [47:0] dquo;
  logic [24:0] drem;
  sdmt_div #(.NumW(48), .DenW(25)) u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i(dnum_q), .den_i(dden_q),
    .busy_o(dbusy), .quo_o(dquo), .rem_o(drem)
  );
  // round half away: quotient+1 when 2*rem >= den
  logic [48:0] rq_mag;
  logic signed [49:0] rq;
  assign rq_mag = {1'b0, dquo} + 49'(({drem, 1'b0} >= {1'b0, dden_q}) ? 1 : 0);
  assign rq     = dneg_q ? -$signed({1'b0, rq_mag}) : $signed({1'b0, rq_mag});

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sh7fff;
    if (v < -50'sd32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // Round a signed value by 2^sh, halves away from zero
  function automatic logic signed [49:0] rsh(input logic signed [49:0] v, input int sh);
    logic [49:0] m;
    m = v < 0 ? 50'(-v) : 50'(v);
    m = (m + (50'd1 << (sh - 1))) >> sh;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] med3(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input logic signed [15:0] c);
    logic signed [15:0] l, h;
    l = a < b ? a : b; h = a < b ? b : a;
    if (c >= l && c <= h) return c;
    l = a < c ? a : c; h = a < c ? c : a;
    if (b >= l && b <= h) return b;
    return a;
  endfunction

  // Sequenced combinational helpers (each at most one multiplier)
  logic signed [49:0] fresh_w, slow_w;
  logic signed [33:0] qd;
  logic signed [49:0] vsum;
  logic [47:0]        zv;
  logic [63:0]        lhs_w;
  logic [63:0]        rhs_w;
  logic [24:0]        nwv;
  logic [24:0]        vclamp;
  logic [17:0]        wsum;

  always_comb begin
    fresh_w = rsh(50'(($signed({1'b0, 8'd125}) - $signed({1'b0, bin_q}))
                  * $signed({1'b0, cfg_i.deg})) <<< FracBits, 8);
    slow_w  = rsh(50'($signed(prod_q)) +
                  50'($signed(18'(WOne) - 18'(cfg_i.keep)) * beam_q), 16);
    // prod_q still holds the squared deviation from the claim test
    qd      = 34'(rsh(50'(prod_q), FracBits));
    vsum    = $signed({26'd0, v_sel}) + rq;
    vclamp  = 25'(vsum < 0 ? 0 : (vsum > 50'sd33554431 ? 50'sd33554431 : vsum));
    if (vclamp < lo_var) vclamp = lo_var;
    if (vclamp > hi_var) vclamp = hi_var;
    if (vclamp > 25'(VarCap)) vclamp = 25'(VarCap);
    zv      = 48'(zsq_q) * 48'(v_sel);
    lhs_w   = {16'd0, prod_q, 16'd0};
    rhs_w   = {16'd0, zv} << FracBits;
    nwv     = lo_var > 25'(VarCap) ? 25'(VarCap) : lo_var;
    wsum    = 18'(bw_q) + 18'(fw_q);
  end

  logic [16:0] w_upd;
  always_comb begin
    w_upd = 17'(32'(w_sel) + 32'(rsh(50'(cfg_i.rate) * (50'(WOne) - 50'(w_sel)), 16)));
  end

  always_comb begin
    sts_o.present   = present_q;
    sts_o.claim     = claim_q;
    sts_o.can_new   = miss_q >= cfg_i.wait_n;
    sts_o.need_norm = (wsum != 18'd0) && (wsum != 18'(WOne));
    sts_o.done      = 1'b1;
    case (cmd_i.op)
      OP_SLOW, OP_CLAIM, OP_MEAN, OP_VAR, OP_NORMB, OP_NORMF:
        sts_o.done = !cmd_i.start && (phase_q == 2'd3) && !dbusy && !div_go_q;
      default: sts_o.done = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0; newer_q <= '0; beam_q <= '0; slow_q <= '0;
      bmean_q <= '0; fmean_q <= '0; talk_q <= '0; run_q <= '0;
      bvar_q <= 24'(1 << FracBits); fvar_q <= 24'(1 << FracBits);
      bw_q <= '0; fw_q <= '0; miss_q <= '0; fflag_q <= 1'b0;
      div_go_q <= 1'b0; phase_q <= '0; claim_q <= 1'b0;
      present_q <= 1'b0; voice_q <= 1'b0; bin_q <= '0;
      dev_q <= '0; prod_q <= '0; dnum_q <= '0; dden_q <= 25'd1; dneg_q <= 1'b0;
      zsq_q <= '0; nbw_q <= '0;
    end else begin
      div_go_q <= cmd_i.start && (cmd_i.op inside {OP_MEAN, OP_VAR, OP_NORMB, OP_NORMF});
      if (load_i) begin
        present_q <= has_data_i; bin_q <= peak_bin_i; voice_q <= voice_i;
      end
      if (cmd_i.start) phase_q <= '0;
      case (cmd_i.op)
        OP_BEAM: begin
          // hold the taps and the beam when the frame has no peak
          if (present_q) begin
            beam_q  <= med3(older_q, newer_q, sat16(fresh_w));
            older_q <= newer_q;
            newer_q <= sat16(fresh_w);
          end
        end
        OP_SLOW: begin
          // start: keep*slow product; phase 0: sum and round
          if (cmd_i.start) prod_q <= 32'($signed({1'b0, cfg_i.keep}) * slow_q);
          else if (phase_q == 2'd0) begin
            slow_q <= sat16(slow_w); phase_q <= 2'd3;
          end
        end
        OP_CLAIM: begin
          if (cmd_i.start) begin
            dev_q <= 17'(beam_q) - 17'(m_sel);
            zsq_q <= 24'(cfg_i.zone) * 24'(cfg_i.zone);
          end else if (phase_q == 2'd0) begin
            prod_q <= 32'(dev_q * dev_q); phase_q <= 2'd1;
          end else if (phase_q == 2'd1) begin
            claim_q <= (w_sel != '0) && (lhs_w < rhs_w); phase_q <= 2'd3;
          end
        end
        OP_MEAN, OP_VAR: begin
          if (cmd_i.start) begin
            if (cmd_i.op == OP_MEAN) begin
              dnum_q <= 48'(dev_q < 0 ? -(50'(cfg_i.rate) * 50'(dev_q))
                                      : 50'(cfg_i.rate) * 50'(dev_q));
              dneg_q <= dev_q < 0;
            end else begin
              dnum_q <= 48'($signed(50'(qd)) - $signed({26'd0, v_sel}) < 0
                       ? -(50'(cfg_i.rate) * ($signed(50'(qd)) - $signed({26'd0, v_sel})))
                       : 50'(cfg_i.rate) * ($signed(50'(qd)) - $signed({26'd0, v_sel})));
              dneg_q <= ($signed(50'(qd)) - $signed({26'd0, v_sel})) < 0;
            end
            dden_q <= 25'(w_sel);
          end else if (phase_q == 2'd0 && !dbusy && !div_go_q) begin
            if (cmd_i.op == OP_MEAN) begin
              if (cmd_i.sel_fore) fmean_q <= sat16(50'(m_sel) + rq);
              else                bmean_q <= sat16(50'(m_sel) + rq);
            end else begin
              if (cmd_i.sel_fore) fvar_q <= 24'(vclamp);
              else                bvar_q <= 24'(vclamp);
            end
            phase_q <= 2'd3;
          end
        end
        OP_WGT: begin
          if (cmd_i.sel_fore) begin fw_q <= w_upd; fflag_q <= 1'b1; end
          else begin bw_q <= w_upd; fflag_q <= 1'b0; end
          miss_q <= '0;
        end
        OP_NEWG: begin
          fmean_q <= beam_q; fvar_q <= 24'(nwv); fw_q <= 17'(cfg_i.rate);
          fflag_q <= 1'b1; miss_q <= '0;
        end
        OP_MISS: miss_q <= miss_q + 8'd1;
        OP_NORMB, OP_NORMF: begin
          if (cmd_i.start) begin
            dnum_q <= 48'(cmd_i.op == OP_NORMF ? fw_q : bw_q) << 16;
            dden_q <= 25'(wsum); dneg_q <= 1'b0;
          end else if (phase_q == 2'd0 && !dbusy && !div_go_q) begin
            // hold the new background weight until both are known
            if (cmd_i.op == OP_NORMB) nbw_q <= 17'(rq_mag);
            else begin
              bw_q <= nbw_q; fw_q <= 17'(rq_mag);
            end
            phase_q <= 2'd3;
          end
        end
        OP_FIN: begin
          if (bw_q < fw_q) begin
            bmean_q <= fmean_q; fmean_q <= bmean_q;
            bvar_q <= fvar_q; fvar_q <= bvar_q;
            bw_q <= fw_q; fw_q <= bw_q;
          end
          if (!voice_q) begin
            run_q <= (run_q < 0) ? ((run_q == 16'sh8000) ? run_q : run_q - 16'sd1)
                                 : -16'sd1;
          end else begin
            if (run_q <= 0) talk_q <= (bw_q < fw_q) ? bmean_q : fmean_q;
            run_q <= (run_q > 0) ? ((run_q == 16'sh7fff) ? run_q : run_q + 16'sd1)
                                 : 16'sd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign beam_o = beam_q;
  assign slow_o = slow_q;
  assign talk_o = talk_q;
  assign fore_o = fflag_q;
  assign run_o  = run_q;

  a_wsum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_NORMF && sts_o.done) |=> (18'(bw_q) + 18'(fw_q) <= 18'(WOne) + 18'd1))
    else $error("renormalised weights exceed one");
  a_var: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bvar_q <= 24'(VarCap)))
    else $error("variance above cap");
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_FIN && voice_q) |=> (run_q > 0))
    else $error("speech run not positive after voice");
endmodule
`default_nettype wire

@@ hdl/sdmt_ctrl.sv @@
// Controller: sequences one frame through the datapath.
`default_nettype none
module sdmt_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_fire_i,
  input  wire logic              out_busy_i,
  input  wire sdmt_pkg::dp_sts_t sts_i,
  output sdmt_pkg::dp_cmd_t      cmd_o,
  output logic                   in_ready_o,
  output logic                   out_push_o
);
  import sdmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BEAM, S_SLOW, S_CLB, S_CLF, S_MEAN, S_VAR, S_WGT,
    S_NEWG, S_MISS, S_CHK, S_NORMB, S_NORMF, S_FIN, S_PUSH
  } state_e;

  state_e state_q;
  logic   start_q, fore_q;

  always_comb begin
    cmd_o.start    = start_q;
    cmd_o.sel_fore = fore_q;
    case (state_q)
      S_BEAM:  cmd_o.op = OP_BEAM;
      S_SLOW:  cmd_o.op = OP_SLOW;
      S_CLB, S_CLF: cmd_o.op = OP_CLAIM;
      S_MEAN:  cmd_o.op = OP_MEAN;
      S_VAR:   cmd_o.op = OP_VAR;
      S_WGT:   cmd_o.op = OP_WGT;
      S_NEWG:  cmd_o.op = OP_NEWG;
      S_MISS:  cmd_o.op = OP_MISS;
      S_NORMB: cmd_o.op = OP_NORMB;
      S_NORMF: cmd_o.op = OP_NORMF;
      S_FIN:   cmd_o.op = OP_FIN;
      default: cmd_o.op = OP_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_push_o = (state_q == S_PUSH) && !out_busy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; start_q <= 1'b0; fore_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_fire_i) begin state_q <= S_BEAM; end
        S_BEAM: begin
          // present is loaded with the transfer; skip the filters without data
          if (sts_i.present) begin state_q <= S_SLOW; start_q <= 1'b1; end
          else begin state_q <= S_CLB; start_q <= 1'b1; fore_q <= 1'b0; end
        end
        S_SLOW: if (sts_i.done) begin
          state_q <= S_CLB; start_q <= 1'b1; fore_q <= 1'b0;
        end
        S_CLB: if (sts_i.done) begin
          if (sts_i.claim) begin state_q <= S_MEAN; start_q <= 1'b1; end
          else begin state_q <= S_CLF; start_q <= 1'b1; fore_q <= 1'b1; end
        end
        S_CLF: if (sts_i.done) begin
          if (sts_i.claim) begin state_q <= S_MEAN; start_q <= 1'b1; end
          else if (sts_i.can_new) state_q <= S_NEWG;
          else state_q <= S_MISS;
        end
        S_MEAN: if (sts_i.done) begin state_q <= S_VAR; start_q <= 1'b1; end
        S_VAR:  if (sts_i.done) state_q <= S_WGT;
        // weights settle at the end of these states; test the sum in S_CHK, the state after
        S_WGT, S_NEWG, S_MISS: state_q <= S_CHK;
        S_CHK: begin
          if (sts_i.need_norm) begin state_q <= S_NORMB; start_q <= 1'b1; end
          else state_q <= S_FIN;
        end
        S_NORMB: if (sts_i.done) begin state_q <= S_NORMF; start_q <= 1'b1; end
        S_NORMF: if (sts_i.done) state_q <= S_FIN;
        S_FIN:   state_q <= S_PUSH;
        S_PUSH:  if (!out_busy_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |=> (state_q == S_BEAM))
    else $error("transfer not started");
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |=> (state_q == S_IDLE))
    else $error("push did not return to idle");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (state_q == S_PUSH))
    else $error("finish skipped the result");
endmodule
`default_nettype wire

@@ hdl/sound_direction_mixture_tracker.sv @@
// Sound direction mixture tracker: one result per input frame. The controller
// holds a finished result while the output register is still full. The frame
// time is set by the shared 48-bit restoring divider (one quotient bit per
// cycle), used up to four times per frame for the mean and variance updates
// and the two weight renormalisations. The result sits in an output register,
// so a frame can be taken while a previous result waits. Configuration writes
// are always accepted.
`default_nettype none
module sound_direction_mixture_tracker #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // has_data[0], peak_bin[8:1], voice[9]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // beam[15:0] slow[31:16] talk[47:32]
                                          // foreground[48] speech_run[64:49]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import sdmt_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_fire, push, ovalid_q;
  logic signed [15:0] beam, slow, talk, run;
  logic    fore;
  logic [71:0] odata_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{deg: 8'd123, keep: 16'd52429, zone: 12'd768, rate: 16'd1311,
                 minsd: 13'd768, maxsd: 13'd2560, wait_n: 8'd5};
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DEG:  cfg_q.deg    <= cfg_data_i[7:0];
        REG_KEEP: cfg_q.keep   <= cfg_data_i;
        REG_ZONE: cfg_q.zone   <= cfg_data_i[11:0];
        REG_RATE: cfg_q.rate   <= cfg_data_i;
        REG_MINS: cfg_q.minsd  <= cfg_data_i[12:0];
        REG_MAXS: cfg_q.maxsd  <= cfg_data_i[12:0];
        REG_WAIT: cfg_q.wait_n <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  sdmt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_busy_i(ovalid_q && !m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(s_axis_tready), .out_push_o(push)
  );

  sdmt_datapath #(.FracBits(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .load_i(in_fire),
    .has_data_i(s_axis_tdata[0]), .peak_bin_i(s_axis_tdata[8:1]),
    .voice_i(s_axis_tdata[9]), .cmd_i(cmd), .sts_o(sts),
    .beam_o(beam), .slow_o(slow), .talk_o(talk), .fore_o(fore), .run_o(run)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (push) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) odata_q <= {7'd0, run, fore, talk, slow, beam};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  logic unused_in;
  assign unused_in = ^s_axis_tdata[15:10];
endmodule
`default_nettype wire

@@ tb/sv/tb_sound_direction_mixture_tracker.sv @@
// Testbench of the sound direction mixture tracker: streams frames, predicts each result.
`timescale 1ns / 100ps
module tb_sound_direction_mixture_tracker;
  import sdmt_pkg::*;

  localparam int FRAC = 8;
  localparam longint ONE_W = 65536;
  localparam longint CAP_V = 16777215;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit [15:0] beam;
    bit [15:0] slow;
    bit [15:0] talk;
    bit        fg;
    bit [15:0] run;
  } track_out_t;

  class track_board;
    longint deg, keep, zone, rate, minsd, maxsd, wait_n;
    longint tap_old, tap_new, beam, slow;
    longint b_mean, b_var, b_w, f_mean, f_var, f_w;
    longint misses, fg, run, talk;
    track_out_t pending[$];
    int errors;

    function new();
      deg = 123; keep = 52429; zone = 768; rate = 1311;
      minsd = 768; maxsd = 2560; wait_n = 5;
      tap_old = 0; tap_new = 0; beam = 0; slow = 0;
      b_mean = 0; f_mean = 0; b_var = 1 << FRAC; f_var = 1 << FRAC;
      b_w = 0; f_w = 0; misses = 0; fg = 0; run = 0; talk = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, longint val);
      case (idx)
        REG_DEG:  deg = val & 'hFF;
        REG_KEEP: keep = val & 'hFFFF;
        REG_ZONE: zone = val & 'hFFF;
        REG_RATE: rate = val & 'hFFFF;
        REG_MINS: minsd = val & 'h1FFF;
        REG_MAXS: maxsd = val & 'h1FFF;
        REG_WAIT: wait_n = val & 'hFF;
        default: ;
      endcase
    endfunction

    function longint rdiv(longint n, longint d);
      longint h;
      h = d / 2;
      if (n >= 0) return (n + h) / d;
      return -((-n + h) / d);
    endfunction

    function longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint sd_sq(longint sd);
      return rdiv(sd * sd, longint'(1) << (16 - FRAC));
    endfunction

    function longint clamp_var(longint v);
      if (v < sd_sq(minsd)) v = sd_sq(minsd);
      if (v > sd_sq(maxsd)) v = sd_sq(maxsd);
      if (v < 0) v = 0;
      if (v > CAP_V) v = CAP_V;
      return v;
    endfunction

    function bit is_claimed(longint dev, longint var_v, longint w);
      if (w <= 0) return 0;
      return (dev * dev * 65536) < (zone * zone * var_v * (longint'(1) << FRAC));
    endfunction

    function void learn(ref longint m, ref longint v, ref longint w, input longint dev);
      longint q;
      q = rdiv(dev * dev, longint'(1) << FRAC);
      m = clip16(m + rdiv(rate * dev, w));
      v = clamp_var(v + rdiv(rate * (q - v), w));
      w = w + rdiv(rate * (ONE_W - w), ONE_W);
    endfunction

    function void update_mixture(longint x);
      longint sum, t;
      if (is_claimed(x - b_mean, b_var, b_w)) begin
        learn(b_mean, b_var, b_w, x - b_mean);
        fg = 0;
        misses = 0;
      end else if (is_claimed(x - f_mean, f_var, f_w)) begin
        learn(f_mean, f_var, f_w, x - f_mean);
        fg = 1;
        misses = 0;
      end else if (misses >= wait_n) begin
        f_mean = x;
        f_var = sd_sq(minsd);
        if (f_var > CAP_V) f_var = CAP_V;
        f_w = rate;
        fg = 1;
        misses = 0;
      end else begin
        misses++;
      end
      sum = b_w + f_w;
      if (sum > 0 && sum != ONE_W) begin
        b_w = rdiv(b_w * ONE_W, sum);
        f_w = rdiv(f_w * ONE_W, sum);
      end
      if (b_w < f_w) begin
        t = b_mean; b_mean = f_mean; f_mean = t;
        t = b_var; b_var = f_var; f_var = t;
        t = b_w; b_w = f_w; f_w = t;
      end
    endfunction

    function longint mid3(longint a, longint b, longint c);
      if ((c >= a && c <= b) || (c >= b && c <= a)) return c;
      if ((b >= a && b <= c) || (b >= c && b <= a)) return b;
      return a;
    endfunction

    // Note one accepted frame and queue the result it must produce
    function void note_frame(bit has, bit [7:0] bin, bit voice);
      longint fresh, r;
      track_out_t e;
      if (has) begin
        fresh = clip16(rdiv((125 - longint'(bin)) * deg * (longint'(1) << FRAC), 256));
        beam = mid3(tap_old, tap_new, fresh);
        tap_old = tap_new;
        tap_new = fresh;
        slow = clip16(rdiv(keep * slow + (ONE_W - keep) * beam, ONE_W));
      end
      update_mixture(beam);
      if (!voice) begin
        r = run < 0 ? run : 0;
        run = r > -32768 ? r - 1 : -32768;
      end else begin
        r = run > 0 ? run : 0;
        if (run <= 0) talk = f_mean;
        run = r < 32767 ? r + 1 : 32767;
      end
      e.beam = beam[15:0]; e.slow = slow[15:0]; e.talk = talk[15:0];
      e.fg = fg[0]; e.run = run[15:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic [71:0] d);
      track_out_t e;
      if (pending.size() == 0) begin
        $display("%0t: result %h with none expected", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.beam) begin
        $display("%0t: beam exp %h got %h", $time, e.beam, d[15:0]); errors++;
      end
      if (d[31:16] !== e.slow) begin
        $display("%0t: slow exp %h got %h", $time, e.slow, d[31:16]); errors++;
      end
      if (d[47:32] !== e.talk) begin
        $display("%0t: talk exp %h got %h", $time, e.talk, d[47:32]); errors++;
      end
      if (d[48] !== e.fg) begin
        $display("%0t: foreground exp %b got %b", $time, e.fg, d[48]); errors++;
      end
      if (d[64:49] !== e.run) begin
        $display("%0t: speech run exp %h got %h", $time, e.run, d[64:49]); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // has_data[0], peak_bin[8:1], voice[9]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;       // beam, slow, talk, foreground, speech_run
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  track_board board = new();
  bit steady = 0;   // no idling on either side while set
  int quiet_cycles = 0;

  sound_direction_mixture_tracker u_dut (.*);

  initial forever #5 clk_i = ~clk_i;

  // Receiver: check each result transfer, stall at random
  initial forever begin
    @(posedge clk_i);
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    m_axis_tready <= steady || ($urandom_range(99) >= 21);
  end

  // Watchdog on cycles without any transfer
  initial forever begin
    @(posedge clk_i);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_frame(bit has, bit [7:0] bin, bit voice);
    if (!steady && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, voice, bin, has};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_frame(has, bin, voice);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, val);
  endtask

  task automatic load_regs(int unsigned d, int unsigned k, int unsigned z, int unsigned r,
                           int unsigned lo, int unsigned hi, int unsigned w);
    write_reg(REG_DEG, d);
    write_reg(REG_KEEP, k);
    write_reg(REG_ZONE, z);
    write_reg(REG_RATE, r);
    write_reg(REG_MINS, lo);
    write_reg(REG_MAXS, hi);
    write_reg(REG_WAIT, w);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly steady talkers with jitter; the rest noise
  task automatic random_frames(int count);
    int sent, len, centre, jit;
    bit voice;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        centre = $urandom_range(250);
        jit = $urandom_range(4);
        len = $urandom_range(40, 4);
        voice = $urandom_range(1);
        repeat (len) begin
          send_frame($urandom_range(99) < 90,
                     8'(centre + $urandom_range(2 * jit) - jit),
                     ($urandom_range(99) < 10) ? ~voice : voice);
          sent++;
        end
      end else begin
        repeat ($urandom_range(8, 1)) begin
          send_frame($urandom_range(1), 8'($urandom_range(255)), $urandom_range(1));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bin extremes, out-of-range bins, no-data hold, voice edges
    send_frame(1, 8'd125, 1);
    send_frame(1, 8'd0, 1);
    send_frame(1, 8'd250, 0);
    send_frame(1, 8'd255, 0);
    send_frame(1, 8'd251, 1);
    send_frame(0, 8'd7, 1);
    send_frame(0, 8'd200, 0);
    repeat (8) send_frame(1, 8'd60, 1);
    repeat (6) send_frame(1, 8'd190, 0);
    send_frame(0, 8'd0, 1);
    drain();

    random_frames(450);
    drain();

    // Extremes: widest angles, zero keep, full rate, no wait
    load_regs(255, 0, 4095, 65535, 0, 8191, 0);
    repeat (6) send_frame(1, 8'd0, 1);
    repeat (6) send_frame(1, 8'd255, 0);
    random_frames(350);
    drain();

    // Other extremes: zero zone and rate, crossed limits, longest wait
    load_regs(0, 65535, 0, 0, 8191, 0, 255);
    random_frames(300);
    drain();

    load_regs(200, 30000, 200, 8000, 100, 6000, 2);
    steady = 1;
    random_frames(300);
    steady = 0;
    drain();

    load_regs($urandom_range(255), $urandom_range(65535), $urandom_range(4095),
              $urandom_range(65535), $urandom_range(8191), $urandom_range(8191),
              $urandom_range(10));
    random_frames(300);
    drain();

    load_regs(123, 52429, 768, 1311, 768, 2560, 5);
    random_frames(230);
    drain();

    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
